FILE: rtl/vpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared types and constants for the variable partition allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;
  localparam int MaxSegmentsDefault = 64;
  localparam int MemUnitsDefault    = 65536;

  // FIT_SPARE is not a placement rule of its own; it behaves as first fit
  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_SPARE = 2'd3
  } fit_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWEEP_RD,
    ST_SWEEP,
    ST_SWEEP_END,
    ST_PLACE,
    ST_SHIFT_RD,
    ST_SHIFT,
    ST_WRITE,
    ST_STATS_RD,
    ST_STATS,
    ST_DONE
  } state_t;
endpackage
`default_nettype wire

FILE: rtl/variable_partition_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// variable_partition_allocator
// Segment-table allocator with expiry, hole merging and first/best/worst fit.
// ----------------------------------------------------------------------------
// Usage: pulse start with the request fields while busy is low; one beat is
// one tick. busy rises for the whole tick. The result appears on the result
// ports for one cycle with done high; the receiver cannot stall it.
// Each tick is run by a sequencer around the segment memory (one read, one
// write per cycle, registered read data):
//   sweep: expire and merge in one compacting pass
//   (fit search runs in the same pass over the merged entries),
//   shift: open a slot for a split,
//   place: write the granted entry, then any split remainder,
//   stats: one more pass counting holes and used units;
// done rises the cycle after the stats pass and busy drops with it.
// After reset the table is seeded with one free segment in ST_INIT; no
// item is accepted in that state. fit_policy is written with cfg_we and may
// change only between ticks.
// ----------------------------------------------------------------------------
module variable_partition_allocator #(
  parameter int MAX_SEGMENTS = vpa_pkg::MaxSegmentsDefault,
  parameter int MEM_UNITS    = vpa_pkg::MemUnitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        has_request,
  input  wire logic [16:0] request_size,
  input  wire logic [15:0] request_owner,
  input  wire logic [15:0] request_lifetime,
  output logic             done,
  output logic             request_granted,
  output logic [15:0]      grant_start,
  output logic [6:0]       released_count,
  output logic [6:0]       hole_count,
  output logic [16:0]      used_units,
  output logic [31:0]      failure_count
);
  import vpa_pkg::*;

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int UW = $clog2(MEM_UNITS + 1);
  localparam int EW = UW + UW + 1 + 16 + 32;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_SEGMENTS);

  typedef struct packed {
    logic [UW-1:0] start_a;
    logic [UW-1:0] size;
    logic          busy_f;
    logic [15:0]   owner;
    logic [31:0]   expiry;
  } entry_t;

  state_t state, state_next;

  logic [1:0]    fit_policy;
  logic [31:0]   tick_now, fail_total;
  logic [CW-1:0] seg_used;
  logic [CW-1:0] rd_idx, wr_idx;
  entry_t        acc;
  logic          acc_vld;
  logic          rq_has;
  logic [16:0]   rq_size;
  logic [15:0]   rq_owner;
  logic [15:0]   rq_life;
  logic [CW-1:0] released;
  logic          pick_vld;
  logic [AW-1:0] pick;
  entry_t        pick_e;
  logic [CW-1:0] holes;
  logic [UW:0]   used;
  logic          granted;
  logic [UW-1:0] gstart;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata;
  logic [EW-1:0] mem_rdata;
  entry_t        rd_e;

  assign rd_e = entry_t'(mem_rdata);

  vpa_seg_mem #(.Depth(MAX_SEGMENTS), .Width(EW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // candidate check for fit on a merged entry
  function automatic logic better(input entry_t e, input logic have,
                                  input entry_t cur, input logic [1:0] pol,
                                  input logic [16:0] sz);
    logic fits;
    fits = !e.busy_f && ({{(UW > 17 ? 0 : 17 - UW + 1){1'b0}}, e.size} >=
           {{(UW > 17 ? UW - 17 + 1 : 1){1'b0}}, sz});
    if (!fits || sz == 17'd0) return 1'b0;
    if (!have) return 1'b1;
    if (pol == FIT_BEST)  return e.size < cur.size;
    if (pol == FIT_WORST) return e.size > cur.size;
    return 1'b0;
  endfunction

  entry_t rd_exp;
  logic   rd_rel;
  always_comb begin
    rd_exp = rd_e;
    rd_rel = rd_e.busy_f && (rd_e.expiry == tick_now);
    if (rd_rel) rd_exp.busy_f = 1'b0;
  end

  logic [UW-1:0] split_rest;
  assign split_rest = pick_e.size - UW'(rq_size);

  logic [AW-1:0] rd_a, wr_a, pick_a1;
  assign rd_a = rd_idx[AW-1:0];
  assign wr_a = wr_idx[AW-1:0];
  assign pick_a1 = pick + AW'(1);

  always_comb begin
    state_next = state;
    mem_we    = 1'b0;
    mem_waddr = wr_a;
    mem_wdata = acc;
    mem_raddr = rd_a;
    unique case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = '{start_a: '0, size: UW'(MEM_UNITS), busy_f: 1'b0,
                      owner: '0, expiry: '0};
        state_next = ST_IDLE;
      end
      ST_IDLE:      if (start) state_next = ST_SWEEP_RD;
      ST_SWEEP_RD:  state_next = ST_SWEEP;
      ST_SWEEP: begin
        // flush accumulator when the new entry cannot merge into it
        if (acc_vld && !(!acc.busy_f && !rd_exp.busy_f)) begin
          mem_we = 1'b1;
        end
        if (rd_idx + CW'(1) >= seg_used) state_next = ST_SWEEP_END;
        else state_next = ST_SWEEP_RD;
      end
      ST_SWEEP_END: begin
        mem_we = 1'b1;
        state_next = ST_PLACE;
      end
      ST_PLACE: begin
        if (!rq_has || !pick_vld) state_next = ST_STATS_RD;
        else if (split_rest != '0 && seg_used >= MaxCnt) state_next = ST_STATS_RD;
        else if (split_rest != '0 && rd_idx > {1'b0, pick_a1})
          state_next = ST_SHIFT_RD;
        else state_next = ST_WRITE;
      end
      ST_SHIFT_RD: state_next = ST_SHIFT;
      ST_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = wr_a;
        mem_wdata = rd_e;
        if (rd_idx == {1'b0, pick_a1}) state_next = ST_WRITE;
        else state_next = ST_SHIFT_RD;
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = pick;
        mem_wdata = '{start_a: pick_e.start_a, size: UW'(rq_size), busy_f: 1'b1,
                      owner: rq_owner, expiry: tick_now + 32'(rq_life)};
        if (split_rest == '0) state_next = ST_STATS_RD;
        else state_next = ST_DONE;
      end
      ST_DONE: begin
        // second write: the split-off remainder
        mem_we    = 1'b1;
        mem_waddr = pick_a1;
        mem_wdata = '{start_a: pick_e.start_a + UW'(rq_size), size: split_rest,
                      busy_f: 1'b0, owner: '0, expiry: '0};
        state_next = ST_STATS_RD;
      end
      ST_STATS_RD: state_next = ST_STATS;
      ST_STATS: begin
        if (rd_idx + CW'(1) >= seg_used) state_next = ST_IDLE;
        else state_next = ST_STATS_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_INIT;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy <= FIT_FIRST;
      tick_now   <= '0;
      fail_total <= '0;
      seg_used   <= CW'(1);
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) fit_policy <= cfg_data;
      unique case (state)
        ST_INIT: ;
        ST_IDLE: if (start) begin
          rq_has   <= has_request;
          rq_size  <= request_size;
          rq_owner <= request_owner;
          rq_life  <= request_lifetime;
          rd_idx   <= '0;
          wr_idx   <= '0;
          acc_vld  <= 1'b0;
          released <= '0;
          pick_vld <= 1'b0;
          granted  <= 1'b0;
          gstart   <= '0;
        end
        ST_SWEEP_RD: ;
        ST_SWEEP: begin
          if (rd_rel) released <= released + CW'(1);
          if (acc_vld && !acc.busy_f && !rd_exp.busy_f) begin
            acc.size <= acc.size + rd_exp.size;
            // fit is checked once the whole run is flushed
          end else begin
            if (acc_vld) begin
              if (better(acc, pick_vld, pick_e, fit_policy, rq_size)) begin
                pick_vld <= 1'b1;
                pick     <= wr_a;
                pick_e   <= acc;
              end
              wr_idx <= wr_idx + CW'(1);
            end
            acc     <= rd_exp;
            acc_vld <= 1'b1;
          end
          rd_idx <= rd_idx + CW'(1);
        end
        ST_SWEEP_END: begin
          if (better(acc, pick_vld, pick_e, fit_policy, rq_size)) begin
            pick_vld <= 1'b1;
            pick     <= wr_a;
            pick_e   <= acc;
          end
          seg_used <= wr_idx + CW'(1);
          rd_idx   <= wr_idx + CW'(1);
        end
        ST_PLACE: begin
          if (rq_has && (!pick_vld || (split_rest != '0 && seg_used >= MaxCnt))) begin
            if (fail_total != '1) fail_total <= fail_total + 32'd1;
          end
          if (rq_has && pick_vld && split_rest != '0 && seg_used < MaxCnt) begin
            wr_idx   <= seg_used;
            rd_idx   <= seg_used - CW'(1);
            seg_used <= seg_used + CW'(1);
          end
        end
        ST_SHIFT_RD: ;
        ST_SHIFT: begin
          wr_idx <= wr_idx - CW'(1);
          rd_idx <= rd_idx - CW'(1);
        end
        ST_WRITE: begin
          granted <= 1'b1;
          gstart  <= pick_e.start_a;
        end
        ST_DONE: ;
        ST_STATS_RD: ;
        ST_STATS: begin
          if (rd_e.busy_f) used <= used + (UW+1)'(rd_e.size);
          else holes <= holes + CW'(1);
          rd_idx <= rd_idx + CW'(1);
          if (rd_idx + CW'(1) >= seg_used) begin
            done     <= 1'b1;
            tick_now <= tick_now + 32'd1;
          end
        end
        default: ;
      endcase
      if (state_next == ST_STATS_RD && state != ST_STATS) begin
        rd_idx <= '0;
        holes  <= '0;
        used   <= '0;
      end
    end
  end

  // result registers are shown while done is high
  always_comb begin
    request_granted = granted;
    grant_start     = 16'(gstart);
    released_count  = 7'(released);
    hole_count      = 7'(holes);
    used_units      = 17'(used);
    failure_count   = fail_total;
  end

  assign busy = (state != ST_IDLE);

  // ST_SHIFT read index wraps handled: rd_idx in ST_SHIFT_RD points at source

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    seg_used <= MaxCnt && seg_used != '0)
    else $error("segment count out of range");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");
  a_fail_sat: assert property (@(posedge clk) disable iff (rst)
    $past(fail_total) == 32'hFFFF_FFFF && !$past(rst) |-> fail_total == 32'hFFFF_FFFF)
    else $error("failure count left saturation");
  a_grant_done: assert property (@(posedge clk) disable iff (rst)
    done && request_granted |-> rq_has)
    else $error("grant without request");
endmodule
`default_nettype wire

FILE: rtl/vpa_seg_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vpa_seg_mem
// Segment table memory: one write port, one registered read port.
// Entry word: {start, size, busy, owner, expiry}.
// ----------------------------------------------------------------------------
module vpa_seg_mem #(
  parameter int Depth = 64,
  parameter int Width = 82
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
